/* hdl/bgd_pkg.sv */
// bgd_pkg: shared constants and width helpers for the box GIoU distance block.
// Used by the top, front, queue and back modules and the testbench; no dependencies.
`timescale 1ns / 1ps
package bgd_pkg;

  // Default coordinate width of one box field
  localparam int unsigned COORD_BITS_DEF = 12;
  // Default number of fraction bits in the distance
  localparam int unsigned FRAC_BITS_DEF  = 16;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Width of an area: (2^C) * (2^C) plus headroom for the union sum
  function automatic int unsigned area_w(input int unsigned c);
    return 2 * c + 2;
  endfunction

endpackage

/* hdl/bgd_if.sv */
// bgd_if: valid/ready channel interfaces for box pairs and distances.
// Depends on nothing; widths come from the interface parameters.
`timescale 1ns / 1ps
interface bgd_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_a_x;
  logic [COORD_BITS-1:0] box_a_y;
  logic [COORD_BITS-1:0] box_a_w;
  logic [COORD_BITS-1:0] box_a_h;
  logic [COORD_BITS-1:0] box_b_x;
  logic [COORD_BITS-1:0] box_b_y;
  logic [COORD_BITS-1:0] box_b_w;
  logic [COORD_BITS-1:0] box_b_h;

  modport source (output valid, box_a_x, box_a_y, box_a_w, box_a_h,
                  box_b_x, box_b_y, box_b_w, box_b_h, input ready);
  modport sink   (input valid, box_a_x, box_a_y, box_a_w, box_a_h,
                  box_b_x, box_b_y, box_b_w, box_b_h, output ready);
endinterface

interface bgd_out_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

/* hdl/box_giou_distance.sv */
// box_giou_distance: top level, front geometry, queue and divider back end.
// Depends on bgd_pkg, bgd_if, bgd_front, bgd_queue and bgd_back.
`timescale 1ns / 1ps
// Takes one box pair per cycle while the output is not stalled and returns
// 2 - I/min(A,B) - U/E as unsigned fixed point with FRAC_BITS fraction bits,
// truncated. An item passes 2 front stages, the queue, 3 back stages and
// FRAC_BITS+1 divider stages; the divider produces one quotient bit per stage.
// The QUEUE_DEPTH-entry queue lets the front keep taking items while the
// output is stalled, until the queue is full.
module box_giou_distance #(
  parameter int unsigned COORD_BITS = bgd_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = bgd_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bgd_in_if.sink    in_ch,
  bgd_out_if.source out_ch
);
  localparam int unsigned GW = 4 * bgd_pkg::area_w(COORD_BITS);

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [GW-1:0] f_data, b_data;

  bgd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_ch,
    .geo_valid(f_valid), .geo_ready(f_ready), .geo_data(f_data)
  );

  bgd_queue #(.WIDTH(GW)) u_queue (
    .clk, .rst_n,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  bgd_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .geo_valid(b_valid), .geo_ready(b_ready), .geo_data(b_data), .out_ch
  );
endmodule

/* hdl/bgd_front.sv */
// bgd_front: box geometry front end (side lengths, overlap, enclosure, areas).
// Depends on bgd_pkg and bgd_in_if; two stalling pipeline stages.
`timescale 1ns / 1ps
module bgd_front #(
  parameter int unsigned COORD_BITS = bgd_pkg::COORD_BITS_DEF,
  localparam int unsigned AW = bgd_pkg::area_w(COORD_BITS),
  localparam int unsigned GW = 4 * AW
) (
  input  logic          clk,
  input  logic          rst_n,
  bgd_in_if.sink        in_ch,
  output logic          geo_valid,
  input  logic          geo_ready,
  output logic [GW-1:0] geo_data
);
  localparam int unsigned LW = COORD_BITS + 1;

  logic          en;
  logic          v1_r, v2_r;
  logic [LW-1:0] saw_r, sah_r, sbw_r, sbh_r, ovx_r, ovy_r, enx_r, eny_r;
  logic [AW-1:0] area_a_r, area_b_r, inter_r, encl_r;

  // Whole front advances when its last stage is empty or drains
  assign en          = !v2_r || geo_ready;
  assign in_ch.ready = en;

  // Overlap (clamped) and enclosing lengths on one axis, inclusive pixels
  function automatic logic [LW-1:0] ov_len(input logic [LW-1:0] s0, input logic [LW-1:0] l0,
                                           input logic [LW-1:0] s1, input logic [LW-1:0] l1);
    logic [LW-1:0] lo, hi, e0, e1;
    e0 = s0 + l0;
    e1 = s1 + l1;
    lo = (s0 > s1) ? s0 : s1;
    hi = (e0 < e1) ? e0 : e1;
    return (hi >= lo) ? LW'(hi - lo + LW'(1)) : '0;
  endfunction

  function automatic logic [LW-1:0] enc_len(input logic [LW-1:0] s0, input logic [LW-1:0] l0,
                                            input logic [LW-1:0] s1, input logic [LW-1:0] l1);
    logic [LW-1:0] lo, hi, e0, e1;
    e0 = s0 + l0;
    e1 = s1 + l1;
    lo = (s0 < s1) ? s0 : s1;
    hi = (e0 > e1) ? e0 : e1;
    return LW'(hi - lo + LW'(1));
  endfunction

  // Stage 1: lengths
  always_ff @(posedge clk) begin
    if (en) begin
      saw_r <= {1'b0, in_ch.box_a_w} + LW'(1);
      sah_r <= {1'b0, in_ch.box_a_h} + LW'(1);
      sbw_r <= {1'b0, in_ch.box_b_w} + LW'(1);
      sbh_r <= {1'b0, in_ch.box_b_h} + LW'(1);
      ovx_r <= ov_len({1'b0, in_ch.box_a_x}, {1'b0, in_ch.box_a_w},
                      {1'b0, in_ch.box_b_x}, {1'b0, in_ch.box_b_w});
      ovy_r <= ov_len({1'b0, in_ch.box_a_y}, {1'b0, in_ch.box_a_h},
                      {1'b0, in_ch.box_b_y}, {1'b0, in_ch.box_b_h});
      enx_r <= enc_len({1'b0, in_ch.box_a_x}, {1'b0, in_ch.box_a_w},
                       {1'b0, in_ch.box_b_x}, {1'b0, in_ch.box_b_w});
      eny_r <= enc_len({1'b0, in_ch.box_a_y}, {1'b0, in_ch.box_a_h},
                       {1'b0, in_ch.box_b_y}, {1'b0, in_ch.box_b_h});
    end
  end

  // Stage 2: four independent small products, full width
  always_ff @(posedge clk) begin
    if (en) begin
      area_a_r <= AW'(saw_r) * AW'(sah_r);
      area_b_r <= AW'(sbw_r) * AW'(sbh_r);
      inter_r  <= AW'(ovx_r) * AW'(ovy_r);
      encl_r   <= AW'(enx_r) * AW'(eny_r);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
  end

  assign geo_valid = v2_r;
  assign geo_data  = {area_a_r, area_b_r, inter_r, encl_r};
endmodule

/* hdl/bgd_queue.sv */
// bgd_queue: short FIFO that decouples the geometry front from the divider back.
// Depends on bgd_pkg for its depth.
`timescale 1ns / 1ps
module bgd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int unsigned DEPTH = bgd_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + PW'(1));
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + PW'(1));
      end
      if (push && !pop) begin
        cnt_r <= CW'(cnt_r + CW'(1));
      end else if (pop && !push) begin
        cnt_r <= CW'(cnt_r - CW'(1));
      end
    end
  end
endmodule

/* hdl/bgd_back.sv */
// bgd_back: products, numerator and restoring divider pipeline, one quotient bit per stage.
// Depends on bgd_pkg and bgd_out_if.
`timescale 1ns / 1ps
module bgd_back #(
  parameter int unsigned COORD_BITS = bgd_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = bgd_pkg::FRAC_BITS_DEF,
  localparam int unsigned AW = bgd_pkg::area_w(COORD_BITS),
  localparam int unsigned GW = 4 * AW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          geo_valid,
  output logic          geo_ready,
  input  logic [GW-1:0] geo_data,
  bgd_out_if.source     out_ch
);
  localparam int unsigned NW = 2 * AW + 1;
  localparam int unsigned NS = FRAC_BITS + 1;

  logic          en;
  logic          v1_r, v2_r, v3_r;
  logic [NS-1:0] vd_r;
  logic [AW-1:0] area_a, area_b, inter, encl;
  logic [AW-1:0] small_r, uni_r, inter1_r, encl1_r;
  logic [NW-1:0] den2_r, pie_r, pus_r;
  logic [NW-1:0] num3_r, den3_r;
  logic [NW-1:0] rem_r [NS];
  logic [NW-1:0] dd_r  [NS];
  logic [FRAC_BITS:0] q_r [NS];

  // Back pipeline stalls as one when the output register is held
  assign en        = !out_ch.valid || out_ch.ready;
  assign geo_ready = en;
  assign {area_a, area_b, inter, encl} = geo_data;

  // Stage 1: smaller area and union
  always_ff @(posedge clk) begin
    if (en) begin
      small_r  <= (area_a < area_b) ? area_a : area_b;
      uni_r    <= AW'(area_a + area_b - inter);
      inter1_r <= inter;
      encl1_r  <= encl;
    end
  end

  // Stage 2: the three wide products, operands widened before multiplying
  always_ff @(posedge clk) begin
    if (en) begin
      den2_r <= NW'(small_r) * NW'(encl1_r);
      pie_r  <= NW'(inter1_r) * NW'(encl1_r);
      pus_r  <= NW'(uni_r) * NW'(small_r);
    end
  end

  // Stage 3: numerator 2*den - inter*encl - uni*small
  always_ff @(posedge clk) begin
    if (en) begin
      num3_r <= NW'({den2_r[NW-2:0], 1'b0} - pie_r - pus_r);
      den3_r <= den2_r;
    end
  end

  // Divider: integer bit first, then one fraction bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      if (num3_r >= den3_r) begin
        rem_r[0] <= NW'(num3_r - den3_r);
        q_r[0]   <= (FRAC_BITS+1)'(1);
      end else begin
        rem_r[0] <= num3_r;
        q_r[0]   <= '0;
      end
      dd_r[0] <= den3_r;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_div
    logic [NW-1:0] sh;
    assign sh = {rem_r[k-1][NW-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= dd_r[k-1]) begin
          rem_r[k] <= NW'(sh - dd_r[k-1]);
          q_r[k]   <= {q_r[k-1][FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r[k] <= sh;
          q_r[k]   <= {q_r[k-1][FRAC_BITS-1:0], 1'b0};
        end
        dd_r[k] <= dd_r[k-1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vd_r <= '0;
    end else if (en) begin
      v1_r <= geo_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r <= {vd_r[NS-2:0], v3_r};
    end
  end

  assign out_ch.valid    = vd_r[NS-1];
  assign out_ch.distance = q_r[NS-1];

  // Divisor is never zero for a live item
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (den3_r != '0)) else $error("zero divisor");
  // Numerator stays below twice the divisor, so the quotient fits
  a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ({1'b0, num3_r} < {den3_r, 1'b0})) else $error("numerator out of range");
  // Final remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (rem_r[NS-1] < dd_r[NS-1])) else $error("remainder out of range");
endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for box_giou_distance (box pair in, distance out).
// Depends on bgd_pkg, bgd_if and the box_giou_distance RTL.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned CB = bgd_pkg::COORD_BITS_DEF;
  localparam int unsigned FB = bgd_pkg::FRAC_BITS_DEF;
  localparam int unsigned LIMIT = 200000;

  typedef logic [CB-1:0] coord_t;
  typedef logic [FB:0] dist_t;
  typedef struct packed {
    coord_t ax, ay, aw, ah, bx, by, bw, bh;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  bgd_in_if #(.COORD_BITS(CB)) in_ch();
  bgd_out_if #(.FRAC_BITS(FB)) out_ch();

  box_giou_distance #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  pair_t pending_pairs[$];
  dist_t expected_dist[$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 7;
  int unsigned recv_idle = 87;
  bit stim_done = 1'b0;

  // inclusive overlap along one axis, clamped at zero
  function automatic longint unsigned span_overlap(longint s0, longint l0,
                                                   longint s1, longint l1);
    longint lo, hi;
    lo = (s0 > s1) ? s0 : s1;
    hi = ((s0 + l0) < (s1 + l1)) ? (s0 + l0) : (s1 + l1);
    return (hi - lo + 1 > 0) ? hi - lo + 1 : 0;
  endfunction

  function automatic longint unsigned span_enclose(longint s0, longint l0,
                                                   longint s1, longint l1);
    longint lo, hi;
    lo = (s0 < s1) ? s0 : s1;
    hi = ((s0 + l0) > (s1 + l1)) ? (s0 + l0) : (s1 + l1);
    return hi - lo + 1;
  endfunction

  // exact long division of 2 - I/min(A,B) - U/E, truncated
  function automatic dist_t giou_distance(pair_t p);
    logic [127:0] area_a, area_b, inter, encl, smaller, uni, den, num, q;
    area_a = (p.aw + 128'd1) * (p.ah + 128'd1);
    area_b = (p.bw + 128'd1) * (p.bh + 128'd1);
    inter = span_overlap(p.ax, p.aw, p.bx, p.bw) * span_overlap(p.ay, p.ah, p.by, p.bh);
    encl = span_enclose(p.ax, p.aw, p.bx, p.bw) * span_enclose(p.ay, p.ah, p.by, p.bh);
    smaller = (area_a < area_b) ? area_a : area_b;
    uni = area_a + area_b - inter;
    den = smaller * encl;
    num = (den << 1) - inter * encl - uni * smaller;
    q = (num << FB) / den;
    return q[FB:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // append one pair to the stimulus queue
  task automatic queue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // append one predicted distance to the scoreboard
  task automatic queue_expect(dist_t d);
    expected_dist.insert(expected_dist.size(), d);
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    p = pair_t'({$urandom, $urandom, $urandom});
    return p;
  endfunction

  // box pair near each other so overlaps and touches are frequent
  function automatic pair_t near_pair(int unsigned span);
    pair_t p;
    p.ax = coord_t'($urandom_range(0, 4095)); p.ay = coord_t'($urandom_range(0, 4095));
    p.aw = coord_t'($urandom_range(0, span)); p.ah = coord_t'($urandom_range(0, span));
    p.bx = coord_t'(p.ax + $urandom_range(0, 2 * span) - span);
    p.by = coord_t'(p.ay + $urandom_range(0, 2 * span) - span);
    p.bw = coord_t'($urandom_range(0, span)); p.bh = coord_t'($urandom_range(0, span));
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready)
        queue_expect(giou_distance({in_ch.box_a_x, in_ch.box_a_y, in_ch.box_a_w,
            in_ch.box_a_h, in_ch.box_b_x, in_ch.box_b_y, in_ch.box_b_w, in_ch.box_b_h}));
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        pair_t p;
        p = pending_pairs.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.box_a_x, in_ch.box_a_y, in_ch.box_a_w, in_ch.box_a_h,
         in_ch.box_b_x, in_ch.box_b_y, in_ch.box_b_w, in_ch.box_b_h} <= p;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0h", out_ch.distance));
        end else begin
          dist_t e;
          e = expected_dist.pop_front();
          checked++;
          if (out_ch.distance !== e)
            report_mismatch($sformatf("distance %0h, expected %0h", out_ch.distance, e));
        end
      end
    end
  end

  initial begin
    pair_t p;
    in_ch.valid = 1'b0;
    {in_ch.box_a_x, in_ch.box_a_y, in_ch.box_a_w, in_ch.box_a_h,
     in_ch.box_b_x, in_ch.box_b_y, in_ch.box_b_w, in_ch.box_b_h} = '0;
    out_ch.ready = 1'b0;
    // directed: identical, extremes, disjoint, touching, thin boxes
    queue_pair('0);
    queue_pair('1);
    queue_pair({12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0});
    queue_pair({12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0});
    queue_pair({12'd0, 12'd0, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9});
    queue_pair({12'd0, 12'd0, 12'd9, 12'd9, 12'd10, 12'd0, 12'd9, 12'd9});
    queue_pair({12'd10, 12'd10, 12'd0, 12'd100, 12'd10, 12'd10, 12'd100, 12'd0});
    queue_pair({12'd4095, 12'd4095, 12'd4095, 12'd4095,
                12'd4095, 12'd4095, 12'd4095, 12'd4095});
    queue_pair({12'd5, 12'd5, 12'd2, 12'd2, 12'd0, 12'd0, 12'd20, 12'd20});
    queue_pair({12'd4000, 12'd0, 12'd95, 12'd4095, 12'd0, 12'd4000, 12'd4095, 12'd95});
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // random: mostly nearby pairs, some fully random
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle = 87; recv_idle = 7; end
      if (phase == 2) begin send_idle = 0; recv_idle = 0; end
      for (int i = 0; i < 515; i++) begin
        case ($urandom_range(0, 3))
          0: p = rand_pair();
          1: p = near_pair(8);
          default: p = near_pair(300);
        endcase
        queue_pair(p);
      end
      while (pending_pairs.size() > 0 || in_ch.valid) @(posedge clk);
    end
    stim_done = 1'b1;
  end

  // end of run and timeout
  initial begin
    wait (stim_done);
    while (expected_dist.size() > 0 && cycles < LIMIT) @(posedge clk);
    repeat (FB + 20) @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("tb: FAIL");
    end else begin
      $display("tb: checked %0d distances over directed, near and random box pairs,", checked);
      $display("tb: with sender and receiver stalls in turn and at full rate");
      if (errors == 0 && expected_dist.size() == 0) begin
        $display("tb: PASS");
      end else begin
        $display("tb: FAIL");
      end
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("tb: FAIL");
    $finish;
  end
endmodule
